// File: rtl/pctp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel command parser package
// Shared types, character codes, register map and the digit lookup.
// ----------------------------------------------------------------------------
package pctp_pkg;

    localparam int DEF_ROW_STRIDE = 256;

    localparam int LIMIT_W = 9;
    localparam int INDEX_W = 16;
    localparam int VALUE_W = 32;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [LIMIT_W-1:0] RESET_WIDTH_LIMIT  = 9'd256;
    localparam logic [LIMIT_W-1:0] RESET_HEIGHT_LIMIT = 9'd144;

    localparam logic REG_WIDTH_LIMIT  = 1'b0;
    localparam logic REG_HEIGHT_LIMIT = 1'b1;

    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;

    localparam logic signed [9:0] CASE_OFFSET = 10'sd32;
    localparam logic signed [9:0] DIGIT_BASE  = 10'sd48;
    localparam logic signed [9:0] DIGIT_SPAN  = 10'sd22;

    localparam logic [1:0] FIELD_X     = 2'd0;
    localparam logic [1:0] FIELD_Y     = 2'd1;
    localparam logic [1:0] FIELD_COLOR = 2'd2;

    typedef enum logic [1:0] {
        STATUS_WRITE  = 2'd0,
        STATUS_FORMAT = 2'd1,
        STATUS_BOUNDS = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] pixel_index;
        logic [VALUE_W-1:0] color;
    } t_result;

    typedef struct packed {
        logic       is_digit;
        logic [3:0] value;
    } t_digit;

    function automatic logic [3:0] digit_lookup(input logic [4:0] idx);
        logic [3:0] v;
        if (idx <= 5'd9) begin
            v = idx[3:0];
        end else if (idx >= 5'd17 && idx <= 5'd22) begin
            v = 4'(idx - 5'd7);
        end else begin
            v = 4'd0;
        end
        return v;
    endfunction

    function automatic t_digit classify_char(input logic [7:0] b);
        logic signed [9:0] u;
        logic signed [9:0] idx;
        t_digit            r;
        if ((b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) || (b >= CHAR_ZERO && b <= CHAR_NINE)) begin
            u = signed'({2'b00, b});
        end else begin
            u = signed'({2'b00, b}) - CASE_OFFSET;
        end
        idx = u - DIGIT_BASE;
        r.is_digit = (idx >= 10'sd0) && (idx <= DIGIT_SPAN);
        r.value    = digit_lookup(idx[4:0]);
        return r;
    endfunction

endpackage

// File: rtl/pctp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel command parser core
// Holds the per-line parse state and folds in one character per cycle.
// ----------------------------------------------------------------------------
module pctp_parser
    import pctp_pkg::*;
#(
    parameter int ROW_STRIDE = DEF_ROW_STRIDE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_char_byte,
    input  logic               i_last_char,
    input  logic [LIMIT_W-1:0] i_width_limit,
    input  logic [LIMIT_W-1:0] i_height_limit,
    output t_result            o_result,
    output logic               o_result_valid
);

    typedef enum logic [1:0] {
        POS_START = 2'd0,
        POS_ZERO  = 2'd1,
        POS_BODY  = 2'd2
    } t_field_pos;

    logic [1:0]         r_field, n_field;
    logic               r_hex, n_hex;
    t_field_pos         r_pos, n_pos;
    logic [VALUE_W-1:0] r_x, n_x;
    logic [VALUE_W-1:0] r_y, n_y;
    logic [VALUE_W-1:0] r_color, n_color;

    t_digit             w_digit;
    logic               w_skip;
    logic [VALUE_W-1:0] w_acc_cur;
    logic [VALUE_W-1:0] w_acc_next;
    logic [INDEX_W-1:0] w_index;

    assign w_digit = classify_char(i_char_byte);

    always_comb begin
        if (r_field == FIELD_X) begin
            w_acc_cur = r_x;
        end else if (r_field == FIELD_Y) begin
            w_acc_cur = r_y;
        end else begin
            w_acc_cur = r_color;
        end
        if (r_hex) begin
            w_acc_next = {w_acc_cur[VALUE_W-5:0], 4'b0000} + VALUE_W'(w_digit.value);
        end else begin
            w_acc_next = {w_acc_cur[VALUE_W-4:0], 3'b000} + {w_acc_cur[VALUE_W-2:0], 1'b0}
                       + VALUE_W'(w_digit.value);
        end
    end

    always_comb begin
        n_field = r_field;
        n_hex   = r_hex;
        n_pos   = r_pos;
        n_x     = r_x;
        n_y     = r_y;
        n_color = r_color;
        w_skip  = 1'b0;
        if (i_valid) begin
            if (i_last_char) begin
                n_field = FIELD_X;
                n_hex   = 1'b0;
                n_pos   = POS_START;
                n_x     = '0;
                n_y     = '0;
                n_color = '0;
            end else if (r_field < FIELD_COLOR && i_char_byte == CHAR_COMMA) begin
                n_field = r_field + 2'd1;
                n_hex   = 1'b0;
                n_pos   = POS_START;
            end else begin
                unique case (r_pos)
                    POS_START: begin
                        n_pos = (i_char_byte == CHAR_ZERO) ? POS_ZERO : POS_BODY;
                    end
                    POS_ZERO: begin
                        n_pos = POS_BODY;
                        if (i_char_byte == CHAR_LOWER_X) begin
                            n_hex  = 1'b1;
                            w_skip = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (w_digit.is_digit && !w_skip) begin
                    if (r_field == FIELD_X) begin
                        n_x = w_acc_next;
                    end else if (r_field == FIELD_Y) begin
                        n_y = w_acc_next;
                    end else begin
                        n_color = w_acc_next;
                    end
                end
            end
        end
    end

    assign w_index = INDEX_W'(r_y[INDEX_W-1:0] * INDEX_W'(ROW_STRIDE)) + r_x[INDEX_W-1:0];

    always_comb begin
        o_result_valid = i_valid && i_last_char;
        o_result       = '0;
        if (r_field < FIELD_COLOR) begin
            o_result.status = STATUS_FORMAT;
        end else if (r_x >= VALUE_W'(i_width_limit) || r_y >= VALUE_W'(i_height_limit)) begin
            o_result.status = STATUS_BOUNDS;
        end else begin
            o_result.status      = STATUS_WRITE;
            o_result.pixel_index = w_index;
            o_result.color       = r_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field <= FIELD_X;
            r_hex   <= 1'b0;
            r_pos   <= POS_START;
            r_x     <= '0;
            r_y     <= '0;
            r_color <= '0;
        end else begin
            r_field <= n_field;
            r_hex   <= n_hex;
            r_pos   <= n_pos;
            r_x     <= n_x;
            r_y     <= n_y;
            r_color <= n_color;
        end
    end

endmodule

// File: rtl/pixel_command_text_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel command text parser
// Parses "x,y,color" lines one character per word into pixel write results.
// ----------------------------------------------------------------------------
// Throughput: one character word per cycle, sustained while o_in_stall is low,
// set by the accumulator update in the parser core; the input stalls while a
// terminator word waits and the two-entry result buffer is full. A result
// passes the input register, then the result buffer; the buffer absorbs
// output stalls. Synchronous active-low reset clears the parse state and the
// buffers and sets the limits to 256 by 144.
module pixel_command_text_parser_unit
    import pctp_pkg::*;
#(
    parameter int ROW_STRIDE = DEF_ROW_STRIDE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_char_byte,
    input  logic               i_last_char,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [INDEX_W-1:0] o_pixel_index,
    output logic [VALUE_W-1:0] o_color,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [LIMIT_W-1:0] r_width_limit;
    logic [LIMIT_W-1:0] r_height_limit;

    logic               r_in_valid;
    logic [7:0]         r_in_char;
    logic               r_in_last;

    logic               r_out_valid;
    t_result            r_out;
    logic               r_skid_valid;
    t_result            r_skid;

    logic               w_consume;
    logic               w_pop;
    logic               w_push;
    t_result            w_result;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEIGHT_LIMIT) ? DATA_W'(r_height_limit)
                                                   : DATA_W'(r_width_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_limit  <= RESET_WIDTH_LIMIT;
            r_height_limit <= RESET_HEIGHT_LIMIT;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_WIDTH_LIMIT:  r_width_limit  <= pwdata[LIMIT_W-1:0];
                REG_HEIGHT_LIMIT: r_height_limit <= pwdata[LIMIT_W-1:0];
            endcase
        end
    end

    assign o_in_stall = r_in_valid && r_in_last && r_skid_valid;
    assign w_consume  = r_in_valid && !(r_in_last && r_skid_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_char <= i_char_byte;
            r_in_last <= i_last_char;
        end
    end

    pctp_parser #(
        .ROW_STRIDE(ROW_STRIDE)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_consume),
        .i_char_byte   (r_in_char),
        .i_last_char   (r_in_last),
        .i_width_limit (r_width_limit),
        .i_height_limit(r_height_limit),
        .o_result      (w_result),
        .o_result_valid(w_push)
    );

    assign w_pop = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop && r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else if (w_pop || !r_out_valid) begin
            r_out_valid  <= w_push;
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && r_skid_valid) begin
            r_out <= r_skid;
        end else if (w_pop || !r_out_valid) begin
            r_out <= w_result;
        end else if (w_push) begin
            r_skid <= w_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_pixel_index = r_out.pixel_index;
    assign o_color       = r_out.color;

endmodule

// File: rtl/pctp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel command parser port checker
// Watches the top-level ports for buffer and result consistency.
// ----------------------------------------------------------------------------
module pctp_checker
    import pctp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_status,
    input logic [INDEX_W-1:0] o_pixel_index,
    input logic [VALUE_W-1:0] o_color
);

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_pixel_index) && $stable(o_color))
        else $error("Stalled result word changed.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == STATUS_WRITE || o_status == STATUS_FORMAT
            || o_status == STATUS_BOUNDS)
        else $error("Result word carries an undefined status.");

    a_reject_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STATUS_WRITE |-> o_pixel_index == '0 && o_color == '0)
        else $error("Rejected result word carries index or color.");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("Input stalled while no result word is pending.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Reset left a result word pending.");

endmodule

bind pixel_command_text_parser_unit pctp_checker u_pctp_checker (.*);
